// ----- hw/rtl/gss_pkg.sv -----
// Shared types and constants for the golden-section search block.
// Used by the top level and by the shared multiplier; depends on nothing.
package gss_pkg;

    // Default position fraction width (signed Q8.24 positions).
    localparam int FRAC_BITS_DEF = 24;

    // Multiplier operand and product widths.
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // 0.618 as a Q0.32 word.
    localparam logic [31:0] PHI_Q032 = 32'h9E3779B9;

    // Horner constants in Q32.32.
    localparam logic signed [63:0] ACC_M14 = -(64'sd14 <<< 32);
    localparam logic signed [63:0] ACC_P60 = 64'sd60 <<< 32;
    localparam logic signed [63:0] ACC_M70 = -(64'sd70 <<< 32);

    // Register reset values.
    localparam logic [7:0]  MAX_ITER_RST  = 8'd100;
    localparam logic [31:0] WIDTH_TOL_RST = 32'd1;

    // Configuration register indexes.
    localparam logic CFG_MAX_ITER  = 1'b0;
    localparam logic CFG_WIDTH_TOL = 1'b1;

    // Input beat: search interval.
    typedef struct packed {
        logic signed [31:0] start_low;
        logic signed [31:0] start_high;
    } t_in_beat;

    // Output beat: location, value and step count.
    typedef struct packed {
        logic signed [31:0] min_location;
        logic signed [63:0] min_value;
        logic [7:0]         iterations_used;
    } t_out_beat;

endpackage

// ----- hw/rtl/golden_section_search_quartic.sv -----
// Golden-section search for the minimum of g(t) = t^4 - 14t^3 + 60t^2 - 70t.
// Every multiply, for the probe offsets and for each evaluation of g, goes
// through the one shared 33x33 multiplier.
// One search at a time: the input is ready only while the sequencer is idle.
// Synchronous active-low reset clears the sequencer and loads the configuration registers.
module golden_section_search_quartic #(
    parameter int FRAC_BITS = gss_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gss_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gss_pkg::t_out_beat  o_out_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import gss_pkg::*;

    localparam int SHIFT = 32 - FRAC_BITS;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_PHI_MUL = 11'b000_0000_0010,
        S_PHI_RES = 11'b000_0000_0100,
        S_EVAL    = 11'b000_0000_1000,
        S_MUL_LO  = 11'b000_0001_0000,
        S_MUL_HI  = 11'b000_0010_0000,
        S_MUL_SUM = 11'b000_0100_0000,
        S_ADD     = 11'b000_1000_0000,
        S_CHECK   = 11'b001_0000_0000,
        S_MID     = 11'b010_0000_0000,
        S_OUT     = 11'b100_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        D_V1  = 2'd0,
        D_V2  = 2'd1,
        D_RES = 2'd2
    } t_dest;

    localparam logic [1:0] LAST_ROUND = 2'd2;

    // Saturating signed 64-bit add.
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                    input logic signed [63:0] y);
        logic signed [63:0] s;
        s = x + y;
        if (x[63] == y[63] && s[63] != x[63]) begin
            sat_add = x[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sat_add = s;
        end
    endfunction

    t_state              r_state, n_state;
    t_dest               r_dest;
    logic                r_init;
    logic [1:0]          r_round;
    logic [7:0]          r_steps;
    logic [7:0]          r_max_iter;
    logic [31:0]         r_tol;
    logic signed [31:0]  r_a, r_b, r_p1, r_p2, r_t;
    logic signed [63:0]  r_v1, r_v2, r_acc, r_lo;
    logic                r_out_valid;
    t_out_beat           r_out;

    logic signed [MUL_W-1:0]  w_op_a, w_op_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [32:0]       w_diff, w_sum;
    logic signed [33:0]       w_phi, w_probe;
    logic signed [63:0]       w_t_ext, w_acc0, w_hi, w_big, w_lo_sh, w_mp, w_add_k;
    logic                     w_hi_ok, w_stop, w_load_out;

    gss_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .o_prod (w_prod)
    );

    // Interval width, midpoint sum and scaled probe offset.
    assign w_diff  = {r_b[31], r_b} - {r_a[31], r_a};
    assign w_sum   = {r_b[31], r_b} + {r_a[31], r_a};
    assign w_phi   = w_prod[65:32];
    assign w_probe = (r_dest == D_V1) ? ({{2{r_b[31]}}, r_b} - w_phi)
                                      : ({{2{r_a[31]}}, r_a} + w_phi);

    // Horner start: t in Q32.32 minus 14.
    assign w_t_ext = {{32{r_t[31]}}, r_t};
    assign w_acc0  = (w_t_ext <<< SHIFT) + ACC_M14;

    // Floored acc*t >> FRAC_BITS from the high and low partial products.
    assign w_hi    = w_prod[63:0];
    assign w_hi_ok = ((w_hi >>> (63 - SHIFT)) == 64'sd0) ||
                     ((w_hi >>> (63 - SHIFT)) == -64'sd1);
    assign w_big   = w_hi <<< SHIFT;
    assign w_lo_sh = r_lo >>> FRAC_BITS;
    assign w_mp    = !w_hi_ok ? (w_hi[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                              : sat_add(w_big, w_lo_sh);
    assign w_add_k = (r_round == 2'd0) ? ACC_P60 : ACC_M70;

    // Loop exit: step limit reached or interval narrower than the tolerance.
    assign w_stop = (r_steps == r_max_iter) || (w_diff < $signed({1'b0, r_tol}));

    assign w_load_out = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // Multiplier operand selection.
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (r_state)
            S_PHI_MUL: begin
                w_op_a = w_diff;
                w_op_b = $signed({1'b0, PHI_Q032});
            end
            S_MUL_LO: begin
                w_op_a = $signed({1'b0, r_acc[31:0]});
                w_op_b = {r_t[31], r_t};
            end
            S_MUL_HI: begin
                w_op_a = {r_acc[63], r_acc[63:32]};
                w_op_b = {r_t[31], r_t};
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_PHI_MUL;
            S_PHI_MUL: n_state = S_PHI_RES;
            S_PHI_RES: n_state = S_EVAL;
            S_EVAL:    n_state = S_MUL_LO;
            S_MUL_LO:  n_state = S_MUL_HI;
            S_MUL_HI:  n_state = S_MUL_SUM;
            S_MUL_SUM: begin
                if (r_round != LAST_ROUND) begin
                    n_state = S_ADD;
                end else begin
                    case (r_dest)
                        D_V1:    n_state = r_init ? S_PHI_MUL : S_CHECK;
                        D_V2:    n_state = S_CHECK;
                        D_RES:   n_state = S_OUT;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD:     n_state = S_MUL_LO;
            S_CHECK:   n_state = w_stop ? S_MID : S_PHI_MUL;
            S_MID:     n_state = S_EVAL;
            S_OUT:     if (w_load_out) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_max_iter  <= MAX_ITER_RST;
            r_tol       <= WIDTH_TOL_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= w_load_out || (r_out_valid && !i_out_ready);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_ITER:  r_max_iter <= i_cfg_data[7:0];
                    CFG_WIDTH_TOL: r_tol      <= i_cfg_data;
                    default:       r_tol      <= r_tol;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_a     <= i_in_data.start_low;
                r_b     <= i_in_data.start_high;
                r_steps <= 8'd0;
                r_dest  <= D_V1;
                r_init  <= 1'b1;
            end
            S_PHI_RES: begin
                r_t <= w_probe[31:0];
                if (r_dest == D_V1) begin
                    r_p1 <= w_probe[31:0];
                end else begin
                    r_p2 <= w_probe[31:0];
                end
            end
            S_EVAL: begin
                r_acc   <= w_acc0;
                r_round <= 2'd0;
            end
            S_MUL_HI: begin
                r_lo <= w_prod[63:0];
            end
            S_MUL_SUM: begin
                r_acc <= w_mp;
                if (r_round == LAST_ROUND) begin
                    case (r_dest)
                        D_V1: begin
                            r_v1 <= w_mp;
                            if (r_init) begin
                                r_dest <= D_V2;
                                r_init <= 1'b0;
                            end
                        end
                        D_V2:    r_v2 <= w_mp;
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD: begin
                r_acc   <= sat_add(r_acc, w_add_k);
                r_round <= r_round + 2'd1;
            end
            S_CHECK: begin
                if (!w_stop) begin
                    r_steps <= r_steps + 8'd1;
                    if (r_v1 < r_v2) begin
                        // Drop the right side; the left probe becomes the right one.
                        r_b    <= r_p2;
                        r_p2   <= r_p1;
                        r_v2   <= r_v1;
                        r_dest <= D_V1;
                    end else begin
                        // Drop the left side; the right probe becomes the left one.
                        r_a    <= r_p1;
                        r_p1   <= r_p2;
                        r_v1   <= r_v2;
                        r_dest <= D_V2;
                    end
                end
            end
            S_MID: begin
                r_t    <= w_sum[32:1];
                r_dest <= D_RES;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase

        // Output register, loaded when the final value is ready.
        if (w_load_out) begin
            r_out.min_location    <= r_t;
            r_out.min_value       <= r_acc;
            r_out.iterations_used <= r_steps;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hw/rtl/gss_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on gss_pkg for the operand and product widths.
module gss_mul (
    input  logic                                 i_clk,
    input  logic signed [gss_pkg::MUL_W-1:0]     i_op_a,
    input  logic signed [gss_pkg::MUL_W-1:0]     i_op_b,
    output logic signed [gss_pkg::PROD_W-1:0]    o_prod
);
    import gss_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // One full signed product per cycle, registered.
    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
    end

    assign o_prod = r_prod;

endmodule
